>>> sv/rcf_pkg.sv
// Package for the RGB colour fade stepper: widths, codes, payload structs and
// the controller-to-datapath command and status types.
// No dependencies; every other file uses it by scoped names.
`default_nettype none

package rcf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned COLOR_W       = 8;
  localparam int unsigned DUR_W         = 16;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_RED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_GREEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BLUE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd6;

  localparam logic [DUR_W-1:0] DUR_RESET = 16'd1000;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic cmd;
    logic keep_going;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;
    logic               fade_done;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    OP_RED,
    OP_GREEN,
    OP_BLUE,
    OP_DWELL
  } div_op_e;

  typedef struct packed {
    logic    start_latch;
    logic    tick_apply;
    logic    div_start;
    logic    div_store;
    div_op_e div_op;
    logic    emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic m_ge2;
    logic tick_fire;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

>>> sv/rcf_ctrl.sv
// Controller of the colour fade stepper: input handshake, the sequence of
// start, four divisions and emission, and a tick's emission. Uses rcf_pkg.
`default_nettype none

module rcf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_cmd_i,
  output logic                    in_stall_o,
  input  wire rcf_pkg::dp_status_t status_i,
  output rcf_pkg::ctrl_cmd_t      cmd_o
);

  rcf_pkg::ctrl_state_e state_q, state_d;
  rcf_pkg::div_op_e     op_q, op_d;
  logic                 accept;

  assign accept = in_valid_i && (state_q == rcf_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcf_pkg::ST_IDLE;
      op_q    <= rcf_pkg::OP_RED;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      rcf_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == rcf_pkg::CMD_START) begin
            op_d = rcf_pkg::OP_RED;
            if (status_i.m_ge2) begin
              state_d = rcf_pkg::ST_DIV_START;
            end
          end else if (status_i.tick_fire) begin
            state_d = rcf_pkg::ST_EMIT;
          end
        end
      end
      rcf_pkg::ST_DIV_START: begin
        state_d = rcf_pkg::ST_DIV_WAIT;
      end
      rcf_pkg::ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          if (op_q == rcf_pkg::OP_DWELL) begin
            state_d = rcf_pkg::ST_EMIT;
          end else begin
            op_d    = rcf_pkg::div_op_e'(op_q + 2'd1);
            state_d = rcf_pkg::ST_DIV_START;
          end
        end
      end
      rcf_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = rcf_pkg::ST_IDLE;
        end
      end
      default: state_d = rcf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.div_op     = op_q;
    in_stall_o       = 1'b1;
    unique case (state_q)
      rcf_pkg::ST_IDLE: begin
        in_stall_o        = 1'b0;
        cmd_o.start_latch = accept && (in_cmd_i == rcf_pkg::CMD_START);
        cmd_o.tick_apply  = accept && (in_cmd_i == rcf_pkg::CMD_TICK);
      end
      rcf_pkg::ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
      end
      rcf_pkg::ST_DIV_WAIT: begin
        cmd_o.div_store = status_i.div_done;
      end
      rcf_pkg::ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/rcf_div.sv
// Restoring divider of the colour fade stepper: an unsigned dividend by an
// 8-bit divisor, one quotient bit per cycle. Uses rcf_pkg.
`default_nettype none

module rcf_div #(
  parameter int unsigned DW = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [DW-1:0]               dividend_i,
  input  wire logic [rcf_pkg::COLOR_W-1:0] divisor_i,
  output logic                             done_o,
  output logic [DW-1:0]                    quotient_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [rcf_pkg::COLOR_W-1:0] rem_q;
  logic [DW-1:0]               quo_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q, done_q;
  logic [rcf_pkg::COLOR_W:0]   trial, diff;
  logic                        fits;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[rcf_pkg::COLOR_W-1:0] : trial[rcf_pkg::COLOR_W-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> sv/rcf_dp.sv
// Datapath of the colour fade stepper: configuration registers, increments,
// accumulators, dwell counting and the output register. Uses rcf_pkg, rcf_div.
`default_nettype none

module rcf_dp #(
  parameter int unsigned FRAC_BITS = rcf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [rcf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rcf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          keep_going_i,
  input  wire rcf_pkg::ctrl_cmd_t            cmd_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output rcf_pkg::out_item_t                 out_data_o,
  output rcf_pkg::dp_status_t                status_o
);

  localparam int unsigned CW     = rcf_pkg::COLOR_W;
  localparam int unsigned ACC_W  = CW + FRAC_BITS;
  localparam int unsigned STEP_W = FRAC_BITS + 2;
  localparam int unsigned DIV_W  = (ACC_W > rcf_pkg::DUR_W) ? ACC_W : rcf_pkg::DUR_W;
  localparam int unsigned DUR_W  = rcf_pkg::DUR_W;

  logic [CW-1:0]     start_q [3];
  logic [CW-1:0]     end_q   [3];
  logic [DUR_W-1:0]  dur_q;

  logic              active_q;
  logic [CW-1:0]     colors_left_q;
  logic [DUR_W-1:0]  dwell_q, count_q;
  logic              out_valid_q;

  logic [CW-1:0]     adiff_q [3];
  logic              neg_q   [3];
  logic [DUR_W-1:0]  dur_lat_q;
  logic [CW-1:0]     m_q;
  logic [STEP_W-1:0] step_q  [3];
  logic [ACC_W-1:0]  acc_q   [3];
  rcf_pkg::out_item_t out_q;

  logic [CW-1:0]     adiff   [3];
  logic [CW-1:0]     m_max;
  logic              m_ge2;
  logic [DUR_W:0]    count_inc;
  logic              fire;
  logic [DIV_W-1:0]  div_dividend, div_quo;
  logic              div_done;
  logic              neg_sel;
  logic [STEP_W-1:0] mag_ext, step_new;
  logic [DUR_W-1:0]  dwell_new;
  logic [ACC_W-1:0]  acc_nxt [3];
  logic              out_free;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      adiff[i]   = rcf_pkg::abs_diff(start_q[i], end_q[i]);
      acc_nxt[i] = acc_q[i] + {{(ACC_W - STEP_W){step_q[i][STEP_W-1]}}, step_q[i]};
    end
    m_max = adiff[0];
    if (adiff[1] > m_max) m_max = adiff[1];
    if (adiff[2] > m_max) m_max = adiff[2];
  end

  assign m_ge2     = (m_max[CW-1:1] != '0);
  assign count_inc = {1'b0, count_q} + 1'b1;
  assign fire      = active_q && keep_going_i && (count_inc >= {1'b0, dwell_q});
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    div_dividend = '0;
    neg_sel      = 1'b0;
    unique case (cmd_i.div_op)
      rcf_pkg::OP_RED: begin
        div_dividend = DIV_W'(adiff_q[0]) << FRAC_BITS;
        neg_sel      = neg_q[0];
      end
      rcf_pkg::OP_GREEN: begin
        div_dividend = DIV_W'(adiff_q[1]) << FRAC_BITS;
        neg_sel      = neg_q[1];
      end
      rcf_pkg::OP_BLUE: begin
        div_dividend = DIV_W'(adiff_q[2]) << FRAC_BITS;
        neg_sel      = neg_q[2];
      end
      rcf_pkg::OP_DWELL: begin
        div_dividend = DIV_W'(dur_lat_q);
      end
      default: div_dividend = '0;
    endcase
  end

  rcf_div #(
    .DW(DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (m_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign mag_ext   = {1'b0, div_quo[FRAC_BITS:0]};
  assign step_new  = neg_sel ? (~mag_ext + 1'b1) : mag_ext;
  assign dwell_new = (div_quo[DUR_W-1:0] == '0) ? DUR_W'(1) : div_quo[DUR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        start_q[i] <= '0;
        end_q[i]   <= '0;
      end
      dur_q         <= rcf_pkg::DUR_RESET;
      active_q      <= 1'b0;
      colors_left_q <= '0;
      dwell_q       <= DUR_W'(1);
      count_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          rcf_pkg::CFG_START_RED:   start_q[0] <= cfg_data_i[CW-1:0];
          rcf_pkg::CFG_START_GREEN: start_q[1] <= cfg_data_i[CW-1:0];
          rcf_pkg::CFG_START_BLUE:  start_q[2] <= cfg_data_i[CW-1:0];
          rcf_pkg::CFG_END_RED:     end_q[0]   <= cfg_data_i[CW-1:0];
          rcf_pkg::CFG_END_GREEN:   end_q[1]   <= cfg_data_i[CW-1:0];
          rcf_pkg::CFG_END_BLUE:    end_q[2]   <= cfg_data_i[CW-1:0];
          rcf_pkg::CFG_DURATION:    dur_q      <= cfg_data_i[DUR_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.start_latch) begin
        active_q <= m_ge2;
        if (m_ge2) begin
          count_q       <= '0;
          colors_left_q <= m_max - CW'(2);
        end
      end else if (cmd_i.tick_apply && active_q) begin
        if (!keep_going_i) begin
          active_q <= 1'b0;
        end else if (fire) begin
          count_q       <= '0;
          colors_left_q <= colors_left_q - 1'b1;
        end else begin
          count_q <= count_inc[DUR_W-1:0];
        end
      end

      if (cmd_i.emit && (colors_left_q == '0)) begin
        active_q <= 1'b0;
      end

      if (cmd_i.div_store && (cmd_i.div_op == rcf_pkg::OP_DWELL)) begin
        dwell_q <= dwell_new;
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_latch) begin
      m_q       <= m_max;
      dur_lat_q <= dur_q;
      for (int i = 0; i < 3; i++) begin
        adiff_q[i] <= adiff[i];
        neg_q[i]   <= (start_q[i] > end_q[i]);
        acc_q[i]   <= {start_q[i], {FRAC_BITS{1'b0}}};
      end
    end else if (cmd_i.emit) begin
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= acc_nxt[i];
      end
    end

    if (cmd_i.div_store) begin
      unique case (cmd_i.div_op)
        rcf_pkg::OP_RED:   step_q[0] <= step_new;
        rcf_pkg::OP_GREEN: step_q[1] <= step_new;
        rcf_pkg::OP_BLUE:  step_q[2] <= step_new;
        default: ;
      endcase
    end

    if (cmd_i.emit) begin
      out_q.red_out   <= acc_nxt[0][ACC_W-1 -: CW];
      out_q.green_out <= acc_nxt[1][ACC_W-1 -: CW];
      out_q.blue_out  <= acc_nxt[2][ACC_W-1 -: CW];
      out_q.fade_done <= (colors_left_q == '0);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;
  assign status_o.m_ge2     = m_ge2;
  assign status_o.tick_fire = fire;
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = out_free;

endmodule

`default_nettype wire

>>> sv/rgb_color_fade_stepper_top.sv
// Top level of the linear RGB colour fade stepper.
// Uses rcf_pkg, rcf_ctrl and rcf_dp.
//
// Input channel (in_valid_i, in_stall_o, in_data_i): each transaction is a
// command, either a start of a new fade or one millisecond tick; keep_going
// low on a tick aborts a running fade. Output channel (out_valid_o,
// out_stall_i, out_data_o): one transaction per fade colour, with fade_done
// set on the last. The configuration port (cfg_valid_i, cfg_ready_o) always
// accepts writes to the start and end colours and the fade duration; they
// act at the next start.
// Before a start's first colour is in the output register, the three
// increments and the dwell are worked out in turn, sharing one divider
// that yields a quotient bit per cycle. A tick that yields a colour waits
// in the emit state until the output register is free. One command is in
// flight at a time and in_stall_o is high while it is worked on.
// If the receiver stalls, the colour waits in the output register and the
// next command can be taken; a later colour waits until that one is taken.
// Reset clears the fade, zeroes the colours and sets the duration to 1000.
`default_nettype none

module rgb_color_fade_stepper_top #(
  parameter int unsigned FRAC_BITS = rcf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire rcf_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output rcf_pkg::out_item_t                  out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rcf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rcf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  rcf_pkg::ctrl_cmd_t  cmd;
  rcf_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  rcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rcf_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .keep_going_i (in_data_i.keep_going),
    .cmd_i        (cmd),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .status_o     (status)
  );

endmodule

`default_nettype wire

>>> sv/rcf_checker.sv
// Port checker of the colour fade stepper and its bind to the top level.
// Uses rcf_pkg; attaches to rgb_color_fade_stepper_top.
`default_nettype none

module rcf_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire rcf_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire rcf_pkg::out_item_t out_data_o
);

  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("a colour appeared without a command being worked on");

  a_abort_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.cmd == rcf_pkg::CMD_TICK)
     && !in_data_i.keep_going) |=> !in_stall_o)
    else $error("an aborting tick held the input channel");

endmodule

bind rgb_color_fade_stepper_top rcf_checker u_rcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> bench/rgb_color_fade_stepper_top_tb.sv
// Self-checking testbench for rgb_color_fade_stepper_top: directed fades, then random fades.
// Depends on rcf_pkg and the block itself. A built-in fade predictor checks every colour
// transaction against the expected colour while both sides idle and stall at random.
`default_nettype none

module rgb_color_fade_stepper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FB            = rcf_pkg::FRAC_BITS_DEF;
  localparam int          ACC_W         = rcf_pkg::COLOR_W + FB;
  localparam int unsigned SETTLE_CYCLES = 4 * (((ACC_W > 16) ? ACC_W : 16) + 2) + 30;
  localparam int unsigned RANDOM_ITEMS  = 700;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SHOW_LIMIT    = 10;
  localparam logic [rcf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_e;

  logic                           clk_i     = 1'b0;
  logic                           rst_ni    = 1'b0;
  logic                           in_valid  = 1'b0;
  rcf_pkg::in_item_t              in_data   = '0;
  logic                           out_stall = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [rcf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rcf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                           in_stall;
  logic                           out_valid;
  rcf_pkg::out_item_t             out_data;
  logic                           cfg_ready;

  rgb_color_fade_stepper_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Predictor copy of the registers and the fade state.
  logic [rcf_pkg::COLOR_W-1:0] set_start [3];
  logic [rcf_pkg::COLOR_W-1:0] set_end [3];
  logic [rcf_pkg::DUR_W-1:0]   set_duration;
  logic                        fade_on;
  logic [ACC_W-1:0]            acc [3];
  logic signed [ACC_W-1:0]     inc [3];
  logic [7:0]                  colours_left;
  logic [15:0]                 dwell_len;
  logic [15:0]                 dwell_cnt;

  rcf_pkg::out_item_t colour_queue [$];
  int unsigned error_count     = 0;
  int unsigned fade_items      = 0;
  int unsigned starts_taken    = 0;
  int unsigned ticks_taken     = 0;
  int unsigned colours_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned cycle_count     = 0;
  int unsigned burst_left      = 0;
  int unsigned stall_left      = 0;
  stall_mode_e stall_mode      = STALL_NONE;

  function automatic void reset_fade_model();
    for (int c = 0; c < 3; c++) begin
      set_start[c] = '0;
      set_end[c]   = '0;
      acc[c]       = '0;
      inc[c]       = '0;
    end
    set_duration = rcf_pkg::DUR_RESET;
    fade_on      = 1'b0;
    colours_left = '0;
    dwell_len    = 16'd1;
    dwell_cnt    = '0;
  endfunction

  function automatic logic [7:0] channel_span(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic signed [ACC_W-1:0] channel_incr(input logic [7:0] s,
                                                           input logic [7:0] e,
                                                           input logic [7:0] m);
    logic [ACC_W-1:0] mag;
    mag = ACC_W'((int'(channel_span(s, e)) << FB) / int'(m));
    return (e >= s) ? $signed(mag) : -$signed(mag);
  endfunction

  function automatic rcf_pkg::out_item_t next_colour();
    rcf_pkg::out_item_t res;
    for (int c = 0; c < 3; c++) acc[c] = acc[c] + inc[c];
    res.red_out   = acc[0][ACC_W-1 -: rcf_pkg::COLOR_W];
    res.green_out = acc[1][ACC_W-1 -: rcf_pkg::COLOR_W];
    res.blue_out  = acc[2][ACC_W-1 -: rcf_pkg::COLOR_W];
    res.fade_done = (colours_left == 8'd0);
    if (colours_left == 8'd0) fade_on = 1'b0;
    return res;
  endfunction

  function automatic bit fade_model_step(input rcf_pkg::in_item_t it,
                                         output rcf_pkg::out_item_t res);
    logic [7:0] m;
    res = '0;
    if (it.cmd == rcf_pkg::CMD_START) begin
      m = '0;
      for (int c = 0; c < 3; c++)
        if (channel_span(set_start[c], set_end[c]) > m) m = channel_span(set_start[c], set_end[c]);
      fade_on = 1'b0;
      if (m <= 8'd1) return 1'b0;
      for (int c = 0; c < 3; c++) begin
        inc[c] = channel_incr(set_start[c], set_end[c], m);
        acc[c] = {set_start[c], {FB{1'b0}}};
      end
      dwell_len    = (set_duration < 16'(m)) ? 16'd1 : set_duration / 16'(m);
      dwell_cnt    = '0;
      colours_left = m - 8'd2;
      fade_on      = 1'b1;
      res = next_colour();
      return 1'b1;
    end
    if (!fade_on) return 1'b0;
    if (!it.keep_going) begin
      fade_on = 1'b0;
      return 1'b0;
    end
    dwell_cnt = dwell_cnt + 16'd1;
    if (dwell_cnt < dwell_len) return 1'b0;
    dwell_cnt    = '0;
    colours_left = colours_left - 8'd1;
    res = next_colour();
    return 1'b1;
  endfunction

  function automatic void apply_register(input logic [rcf_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [rcf_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      rcf_pkg::CFG_START_RED:   set_start[0] = data[7:0];
      rcf_pkg::CFG_START_GREEN: set_start[1] = data[7:0];
      rcf_pkg::CFG_START_BLUE:  set_start[2] = data[7:0];
      rcf_pkg::CFG_END_RED:     set_end[0]   = data[7:0];
      rcf_pkg::CFG_END_GREEN:   set_end[1]   = data[7:0];
      rcf_pkg::CFG_END_BLUE:    set_end[2]   = data[7:0];
      rcf_pkg::CFG_DURATION:    set_duration = data[rcf_pkg::DUR_W-1:0];
      default: ;
    endcase
  endfunction

  // Observes every transaction at the clock edge: predicts on input, checks on output.
  always @(posedge clk_i) begin
    rcf_pkg::out_item_t want;
    rcf_pkg::out_item_t got;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        if (in_data.cmd == rcf_pkg::CMD_START || fade_on) fade_items++;
        if (in_data.cmd == rcf_pkg::CMD_START) starts_taken++;
        else ticks_taken++;
        if (fade_model_step(in_data, want)) colour_queue.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (colour_queue.size() == 0) begin
          error_count++;
          if (error_count <= SHOW_LIMIT)
            $display("%0t: unexpected colour %0d/%0d/%0d done %0b", $realtime,
                     got.red_out, got.green_out, got.blue_out, got.fade_done);
        end else begin
          want = colour_queue.pop_front();
          colours_checked++;
          if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
              got.blue_out !== want.blue_out || got.fade_done !== want.fade_done) begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
              $display({"%0t: colour mismatch, expected %0d/%0d/%0d done %0b, ",
                        "got %0d/%0d/%0d done %0b"},
                       $realtime, want.red_out, want.green_out, want.blue_out, want.fade_done,
                       got.red_out, got.green_out, got.blue_out, got.fade_done);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(8, 120);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      default:     out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles.", cycle_count);
      $display("** rgb_color_fade_stepper_top: FAILED **");
      $finish;
    end
  end

  task automatic send_cmd(input logic cmd, input logic keep);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid           <= 1'b1;
    in_data.cmd        <= cmd;
    in_data.keep_going <= keep;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (colour_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write_reg(input logic [rcf_pkg::CFG_IDX_W-1:0] idx,
                               input logic [rcf_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic program_fade(input logic [7:0] sr, input logic [7:0] sg, input logic [7:0] sb,
                              input logic [7:0] er, input logic [7:0] eg, input logic [7:0] eb,
                              input logic [15:0] dur);
    cfg_write_reg(rcf_pkg::CFG_START_RED,   {8'($urandom), sr});
    cfg_write_reg(rcf_pkg::CFG_START_GREEN, {8'($urandom), sg});
    cfg_write_reg(rcf_pkg::CFG_START_BLUE,  {8'($urandom), sb});
    cfg_write_reg(rcf_pkg::CFG_END_RED,     {8'($urandom), er});
    cfg_write_reg(rcf_pkg::CFG_END_GREEN,   {8'($urandom), eg});
    cfg_write_reg(rcf_pkg::CFG_END_BLUE,    {8'($urandom), eb});
    cfg_write_reg(rcf_pkg::CFG_DURATION,    dur);
    if ($urandom_range(0, 2) == 0) cfg_write_reg(CFG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_idle_ticks();
    send_cmd(rcf_pkg::CMD_TICK, 1'b1);
    send_cmd(rcf_pkg::CMD_TICK, 1'b0);
    send_cmd(rcf_pkg::CMD_START, 1'b1);
    settle_block();
  endtask

  task automatic test_flat_colours();
    program_fade(8'd30, 8'd30, 8'd30, 8'd30, 8'd30, 8'd30, 16'd1000);
    send_cmd(rcf_pkg::CMD_START, 1'b0);
    settle_block();
    program_fade(8'd10, 8'd200, 8'd77, 8'd11, 8'd199, 8'd77, 16'd1000);
    send_cmd(rcf_pkg::CMD_START, 1'b1);
    send_cmd(rcf_pkg::CMD_TICK, 1'b1);
    settle_block();
  endtask

  task automatic test_full_swing();
    program_fade(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 16'd0);
    send_cmd(rcf_pkg::CMD_START, 1'b1);
    repeat (3) send_cmd(rcf_pkg::CMD_TICK, 1'b1);
    send_cmd(rcf_pkg::CMD_TICK, 1'b0);
    settle_block();
    program_fade(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd128, 16'hFFFF);
    send_cmd(rcf_pkg::CMD_START, 1'b0);
    repeat (2) send_cmd(rcf_pkg::CMD_TICK, 1'b1);
    send_cmd(rcf_pkg::CMD_TICK, 1'b0);
    settle_block();
  endtask

  task automatic test_restart();
    program_fade(8'd0, 8'd100, 8'd50, 8'd20, 8'd90, 8'd50, 16'd40);
    send_cmd(rcf_pkg::CMD_START, 1'b0);
    send_cmd(rcf_pkg::CMD_TICK, 1'b1);
    send_cmd(rcf_pkg::CMD_START, 1'b1);
    send_cmd(rcf_pkg::CMD_TICK, 1'b1);
    settle_block();
  endtask

  task automatic test_fade_to_done();
    program_fade(8'd5, 8'd5, 8'd5, 8'd7, 8'd3, 8'd5, 16'd1);
    send_cmd(rcf_pkg::CMD_START, 1'b1);
    send_cmd(rcf_pkg::CMD_TICK, 1'b1);
    settle_block();
    program_fade(8'd0, 8'd0, 8'd0, 8'd3, 8'd0, 8'd0, 16'd3);
    send_cmd(rcf_pkg::CMD_START, 1'b1);
    send_cmd(rcf_pkg::CMD_TICK, 1'b1);
    settle_block();
  endtask

  task automatic test_cfg_mid_fade();
    program_fade(8'd100, 8'd100, 8'd100, 8'd110, 8'd90, 8'd105, 16'd10);
    send_cmd(rcf_pkg::CMD_START, 1'b1);
    settle_block();
    program_fade(8'd0, 8'd0, 8'd0, 8'd200, 8'd200, 8'd200, 16'd400);
    send_cmd(rcf_pkg::CMD_TICK, 1'b1);
    send_cmd(rcf_pkg::CMD_TICK, 1'b1);
    send_cmd(rcf_pkg::CMD_START, 1'b1);
    settle_block();
  endtask

  task automatic test_random_fades();
    int unsigned base_items;
    int unsigned plan;
    int unsigned dwell;
    int unsigned m;
    int unsigned dur;
    int unsigned pick;
    int          k;
    int          s_col [3];
    int          e_col [3];
    base_items = fade_items;
    while (fade_items - base_items < RANDOM_ITEMS) begin
      settle_block();
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(6, 16))
          send_cmd(($urandom_range(0, 4) == 0) ? rcf_pkg::CMD_START : rcf_pkg::CMD_TICK,
                   1'($urandom));
      end else begin
        k = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 10);
        m = 0;
        for (int c = 0; c < 3; c++) begin
          s_col[c] = $urandom_range(0, 255);
          e_col[c] = s_col[c] + int'($urandom_range(0, 2 * k)) - k;
          if (e_col[c] < 0) e_col[c] = 0;
          if (e_col[c] > 255) e_col[c] = 255;
          if (channel_span(8'(s_col[c]), 8'(e_col[c])) > m)
            m = channel_span(8'(s_col[c]), 8'(e_col[c]));
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) dur = $urandom_range(0, 4 * m);
        else if (pick < 8) dur = $urandom_range(0, m);
        else if (pick == 8) dur = $urandom_range(0, 65535);
        else dur = ($urandom_range(0, 1) != 0) ? 65535 : 0;
        dwell = (m == 0 || dur < m) ? 1 : dur / m;
        plan = (m < 2) ? $urandom_range(0, 3) : dwell * (m - 2) + $urandom_range(0, 3);
        if (plan > 80 && !(plan <= 300 && $urandom_range(0, 5) == 0))
          plan = $urandom_range(5, 60);
        program_fade(8'(s_col[0]), 8'(s_col[1]), 8'(s_col[2]),
                     8'(e_col[0]), 8'(e_col[1]), 8'(e_col[2]), 16'(dur));
        send_cmd(rcf_pkg::CMD_START, 1'($urandom));
        repeat (plan) begin
          pick = $urandom_range(0, 99);
          if (pick < 2) send_cmd(rcf_pkg::CMD_TICK, 1'b0);
          else if (pick < 4) send_cmd(rcf_pkg::CMD_START, 1'($urandom));
          else send_cmd(rcf_pkg::CMD_TICK, 1'b1);
        end
      end
    end
  endtask

  initial begin
    reset_fade_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_ticks();
    test_flat_colours();
    test_full_swing();
    test_restart();
    test_fade_to_done();
    test_cfg_mid_fade();
    test_random_fades();
    settle_block();
    error_count += colour_queue.size();
    $display("Ran %0d starts and %0d ticks over %0d register writes;", starts_taken,
             ticks_taken, cfg_writes);
    $display("%0d fade colours compared, %0d failures.", colours_checked, error_count);
    if (error_count == 0) begin
      $display("** rgb_color_fade_stepper_top: PASSED **");
    end else begin
      $display("** rgb_color_fade_stepper_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> rgb_color_fade_stepper_top.f
sv/rcf_pkg.sv
sv/rcf_ctrl.sv
sv/rcf_div.sv
sv/rcf_dp.sv
sv/rgb_color_fade_stepper_top.sv
sv/rcf_checker.sv
bench/rgb_color_fade_stepper_top_tb.sv
